// ===== hw/rtl/sfc_pkg.sv =====
// Types, constants and CRC-16/ARC functions shared by the safety frame channel.
package sfc_pkg;

    localparam logic [1:0] CFG_ROLE_MASTER   = 2'd0;
    localparam logic [1:0] CFG_MASTER_ID     = 2'd1;
    localparam logic [1:0] CFG_SLAVE_ID      = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd3;

    localparam logic        RST_ROLE_MASTER   = 1'b1;
    localparam logic [7:0]  RST_MASTER_ID     = 8'h01;
    localparam logic [7:0]  RST_SLAVE_ID      = 8'h02;
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd1000;

    localparam logic [4:0] FLAG_SENDER   = 5'h01;
    localparam logic [4:0] FLAG_RECEIVER = 5'h02;
    localparam logic [4:0] FLAG_CRC      = 5'h04;
    localparam logic [4:0] FLAG_SEQ      = 5'h08;
    localparam logic [4:0] FLAG_TIMEOUT  = 5'h10;

    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SEND = 2'd1,
        CMD_RX   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic        role_master;
        logic [7:0]  master_id;
        logic [7:0]  slave_id;
        logic [15:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  rx_sender;
        logic [7:0]  rx_receiver;
        logic [7:0]  rx_count;
        logic [15:0] rx_pay;
        logic [15:0] rx_check;
        logic [15:0] send_payload;
    } t_item;

    typedef struct packed {
        logic        frame_out;
        logic [7:0]  out_sender;
        logic [7:0]  out_receiver;
        logic [7:0]  out_count;
        logic [15:0] out_payload;
        logic [15:0] out_check;
        logic        accepted;
        logic [15:0] accepted_payload;
        logic [4:0]  status_flags;
    } t_result;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] frame_crc(input logic [7:0] snd, input logic [7:0] rcv,
                                              input logic [7:0] cnt, input logic [15:0] pay);
        logic [15:0] c;
        c = crc_byte(16'h0000, snd);
        c = crc_byte(c, rcv);
        c = crc_byte(c, cnt);
        c = crc_byte(c, pay[7:0]);
        c = crc_byte(c, pay[15:8]);
        return c;
    endfunction

endpackage

// ===== hw/rtl/sfc_core.sv =====
// Frame check, reply build and sequence/timeout state for one item per cycle while i_step is high.
module sfc_core import sfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_result o_res
);

    logic [7:0]  r_frame_counter, n_frame_counter;
    logic [4:0]  r_error_flags,   n_error_flags;
    logic [15:0] r_ticks,         n_ticks;

    logic [7:0]  exp_snd, exp_rcv, exp_cnt;
    logic [15:0] rx_crc, tx_crc;
    logic [4:0]  chk_flags;
    logic [7:0]  tx_snd, tx_rcv;
    logic        tx_en;
    logic [15:0] ticks_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_counter <= 8'h00;
            r_error_flags   <= FLAG_TIMEOUT;
            r_ticks         <= 16'h0000;
        end else if (i_step) begin
            r_frame_counter <= n_frame_counter;
            r_error_flags   <= n_error_flags;
            r_ticks         <= n_ticks;
        end
    end

    assign rx_crc = frame_crc(i_item.rx_sender, i_item.rx_receiver,
                              i_item.rx_count, i_item.rx_pay);
    assign tx_crc = frame_crc(tx_snd, tx_rcv, r_frame_counter, i_item.send_payload);

    assign ticks_inc = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 16'd1;

    always_comb begin
        if (i_cfg.role_master) begin
            exp_snd = i_cfg.slave_id;
            exp_rcv = i_cfg.master_id;
            exp_cnt = r_frame_counter - 8'd1;
            tx_snd  = i_cfg.master_id;
            tx_rcv  = i_cfg.slave_id;
        end else begin
            exp_snd = i_cfg.master_id;
            exp_rcv = i_cfg.slave_id;
            exp_cnt = r_frame_counter;
            tx_snd  = i_cfg.slave_id;
            tx_rcv  = i_cfg.master_id;
        end
        chk_flags = r_error_flags & FLAG_TIMEOUT;
        if (i_item.rx_sender != exp_snd)   chk_flags = chk_flags | FLAG_SENDER;
        if (i_item.rx_receiver != exp_rcv) chk_flags = chk_flags | FLAG_RECEIVER;
        if (i_item.rx_check != rx_crc)     chk_flags = chk_flags | FLAG_CRC;
        if (i_item.rx_count != exp_cnt)    chk_flags = chk_flags | FLAG_SEQ;
    end

    always_comb begin
        n_frame_counter = r_frame_counter;
        n_error_flags   = r_error_flags;
        n_ticks         = r_ticks;
        tx_en           = 1'b0;
        o_res           = '0;
        unique case (i_item.cmd)
            CMD_TICK: begin
                n_ticks = ticks_inc;
                if (ticks_inc >= i_cfg.timeout_ticks) begin
                    n_error_flags = r_error_flags | FLAG_TIMEOUT;
                end
            end
            CMD_SEND: begin
                if (i_cfg.role_master) begin
                    tx_en           = 1'b1;
                    n_frame_counter = r_frame_counter + 8'd1;
                end
            end
            CMD_RX: begin
                if (chk_flags == 5'h00) begin
                    o_res.accepted         = 1'b1;
                    o_res.accepted_payload = i_item.rx_pay;
                    if (!i_cfg.role_master) begin
                        tx_en           = 1'b1;
                        n_frame_counter = r_frame_counter + 8'd1;
                    end
                end else if (!i_cfg.role_master
                             && ((chk_flags & (FLAG_SEQ | FLAG_TIMEOUT)) != 5'h00)
                             && ((chk_flags & (FLAG_SENDER | FLAG_RECEIVER | FLAG_CRC))
                                 == 5'h00)) begin
                    // slave resync to the master's counter
                    n_frame_counter = i_item.rx_count + 8'd1;
                end
                n_ticks       = 16'h0000;
                n_error_flags = chk_flags & ~FLAG_TIMEOUT;
            end
            default: begin
            end
        endcase
        if (tx_en) begin
            o_res.frame_out    = 1'b1;
            o_res.out_sender   = tx_snd;
            o_res.out_receiver = tx_rcv;
            o_res.out_count    = r_frame_counter;
            o_res.out_payload  = i_item.send_payload;
            o_res.out_check    = tx_crc;
        end
        o_res.status_flags = n_error_flags;
    end

endmodule

// ===== hw/rtl/safety_frame_channel_top.sv =====
// Safety frame channel top level: config registers, input and result registers.
//
//  channel  dir  handshake                   payload
//  s_axis   in   s_axis_tvalid/tready        tuser cmd, tdata received frame + reply payload
//  m_axis   out  m_axis_tvalid/tready        tuser frame_out/accepted, tdata frame + status
//  cfg      in   i_cfg_valid/o_cfg_ready     i_cfg_index, i_cfg_data
//
// Each item passes the input register, then the result register; one item per cycle while m_axis is ready.
// Each item is checked and its CRC built in the single stage between the input
// register and the result register; state updates as the item leaves that stage.
// A stalled m_axis holds the result register and backs up into s_axis ready.
// Reset (i_rst_n low, synchronous) empties both registers and restores state.
module safety_frame_channel_top import sfc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] rx_sender, [15:8] rx_receiver, [23:16] rx_count, [39:24] rx_pay,
    // [55:40] rx_check, [71:56] send_payload
    input  logic [71:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_sender, [15:8] out_receiver, [23:16] out_count, [39:24] out_payload,
    // [55:40] out_check, [71:56] accepted_payload, [76:72] status_flags, [79:77] zero
    output logic [79:0] m_axis_tdata,
    // [0] frame_out, [1] accepted
    output logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_res;
    logic    step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.role_master   <= RST_ROLE_MASTER;
            r_cfg.master_id     <= RST_MASTER_ID;
            r_cfg.slave_id      <= RST_SLAVE_ID;
            r_cfg.timeout_ticks <= RST_TIMEOUT_TICKS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROLE_MASTER:   r_cfg.role_master   <= i_cfg_data[0];
                CFG_MASTER_ID:     r_cfg.master_id     <= i_cfg_data[7:0];
                CFG_SLAVE_ID:      r_cfg.slave_id      <= i_cfg_data[7:0];
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.cmd          <= s_axis_tuser;
            r_in.rx_sender    <= s_axis_tdata[7:0];
            r_in.rx_receiver  <= s_axis_tdata[15:8];
            r_in.rx_count     <= s_axis_tdata[23:16];
            r_in.rx_pay       <= s_axis_tdata[39:24];
            r_in.rx_check     <= s_axis_tdata[55:40];
            r_in.send_payload <= s_axis_tdata[71:56];
        end
    end

    sfc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cfg   (r_cfg),
        .i_item  (r_in),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out.accepted, r_out.frame_out};
    assign m_axis_tdata  = {3'b000, r_out.status_flags, r_out.accepted_payload,
                            r_out.out_check, r_out.out_payload, r_out.out_count,
                            r_out.out_receiver, r_out.out_sender};

    a_accept_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.accepted) |-> (r_out.status_flags == 5'h00))
        else $error("accepted frame with error flags set");

    a_payload_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_out.accepted) |-> (r_out.accepted_payload == 16'h0000))
        else $error("payload handed on without acceptance");

    a_no_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_out.frame_out) |->
            (r_out.out_sender == 8'h00 && r_out.out_check == 16'h0000))
        else $error("frame fields set with no frame emitted");

    a_rx_clears_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_in.cmd == CMD_RX) |=> !r_out.status_flags[4])
        else $error("received frame left timeout flag set");

endmodule
